### hw/rtl/cpt_pkg.sv
// Shared types, codes and defaults of the client presence table.
package cpt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam logic [15:0] TIMEOUT_RESET = 16'd35;
    localparam logic [3:0] OFFLINE_RESET = 4'd6;

    localparam int ID_W = 31;
    localparam int TIME_W = 32;
    localparam int IN_DATA_W = 40;
    localparam int OUT_DATA_W = 48;

    // Input kinds carried on s_tuser
    localparam logic [1:0] ACT_MSG = 2'd0;
    localparam logic [1:0] ACT_TICK = 2'd1;
    localparam logic [1:0] ACT_SWEEP = 2'd2;

    // Result kinds carried on m_tuser
    localparam logic [2:0] EV_ADDED = 3'd0;
    localparam logic [2:0] EV_UPDATED = 3'd1;
    localparam logic [2:0] EV_DROPPED = 3'd2;
    localparam logic [2:0] EV_OFFLINE = 3'd3;
    localparam logic [2:0] EV_TIMEOUT = 3'd4;
    localparam logic [2:0] EV_DONE = 3'd5;

    // Configuration register indexes
    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_OFFLINE = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [TIME_W-1:0] heard;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MSG_RD,
        ST_MSG_CMP,
        ST_MSG_EMIT,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_OFF_EMIT,
        ST_SW_RD,
        ST_SW_CMP,
        ST_SW_EMIT,
        ST_SW_DONE
    } t_state;

endpackage

### hw/rtl/cpt_store.sv
// Entry memory of the presence table: one write port, one registered read port.
module cpt_store
    import cpt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int IW = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [IW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [IW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/client_presence_table_with_aging.sv
// Top level of the client presence table with timeout aging.
//
// Keeps an ordered table of up to TABLE_DEPTH client ids, each with the
// seconds-clock value at which it was last heard. A message (s_tuser = 0)
// searches the table entry by entry; an unknown id is appended, a known one
// has its time refreshed, and a full table reports a drop. A message whose
// status equals the offline status removes its entry again and the later
// entries move down one slot each. A tick (s_tuser = 1) advances the clock
// with no result; a sweep (s_tuser = 2) walks the table, removes
// and reports every entry older than the timeout, then sends a done result.
// The table sits in a single-port-read memory with registered read data, so
// every visited entry takes an address state, then a compare or move state.
// A sweep that ages out the whole table is the longest item, since every
// removal at slot zero moves all later entries. s_tready is high only between
// items and stays low in reset. Results leave through an output register, and
// the sequencer waits there while m_tready holds it back. The table needs no
// clearing after reset: only entries below the entry count are ever read.
module client_presence_table_with_aging
    import cpt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [15:0]           i_cfg_data,
    // input items
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // client_id[30:0], status[34:31], zero pad
    input  logic [1:0]            i_s_tuser,   // action[1:0]
    // result items
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // slot[3:0], client_out[34:4],
                                               // status_out[38:35], entries_left[43:39], pad
    output logic [2:0]            o_m_tuser,   // event_res[2:0]
    output logic                  o_m_tlast
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    t_state r_state, n_state;
    t_state r_ret, n_ret;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_count, n_count;
    logic [TIME_W-1:0] r_clock, n_clock;
    logic [15:0] r_timeout, n_timeout;
    logic [3:0] r_offst, n_offst;
    logic [ID_W-1:0] r_id, n_id;
    logic [3:0] r_st, n_st;
    logic [2:0] r_ev, n_ev;
    logic [ID_W-1:0] r_gone, n_gone;

    logic r_m_valid, n_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data, n_m_data;
    logic [2:0] r_m_user, n_m_user;
    logic r_m_last, n_m_last;

    // table port
    logic mem_we;
    logic [IW-1:0] mem_waddr;
    t_entry mem_wdata;
    logic [IW-1:0] mem_raddr;
    t_entry mem_rdata;

    // result being emitted this cycle
    logic w_emit;
    logic [2:0] w_ev;
    logic [CW-1:0] w_slot;
    logic [ID_W-1:0] w_oid;
    logic [3:0] w_ost;
    logic w_last;
    logic [31:0] w_slot32;
    logic [31:0] w_left32;

    logic out_free;
    logic [CW-1:0] w_j_next;
    logic [TIME_W-1:0] w_age;

    assign out_free = !r_m_valid || i_m_tready;
    assign w_j_next = r_j + ONE_C;
    assign w_age = r_clock - mem_rdata.heard;

    cpt_store #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .IW(IW)
    ) u_store (
        .i_clk(i_clk),
        .i_we(mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_clock <= '0;
            r_timeout <= TIMEOUT_RESET;
            r_offst <= OFFLINE_RESET;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_clock <= n_clock;
            r_timeout <= n_timeout;
            r_offst <= n_offst;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret <= n_ret;
        r_idx <= n_idx;
        r_pos <= n_pos;
        r_j <= n_j;
        r_id <= n_id;
        r_st <= n_st;
        r_ev <= n_ev;
        r_gone <= n_gone;
        r_m_data <= n_m_data;
        r_m_user <= n_m_user;
        r_m_last <= n_m_last;
    end

    always_comb begin
        n_state = r_state;
        n_ret = r_ret;
        n_idx = r_idx;
        n_pos = r_pos;
        n_j = r_j;
        n_count = r_count;
        n_clock = r_clock;
        n_timeout = r_timeout;
        n_offst = r_offst;
        n_id = r_id;
        n_st = r_st;
        n_ev = r_ev;
        n_gone = r_gone;

        mem_we = 1'b0;
        mem_waddr = r_idx[IW-1:0];
        mem_wdata = '{id: r_id, heard: r_clock};
        mem_raddr = r_idx[IW-1:0];

        w_emit = 1'b0;
        w_ev = r_ev;
        w_slot = r_pos;
        w_oid = r_id;
        w_ost = r_st;
        w_last = 1'b1;

        o_s_tready = 1'b0;

        // registers are to be written only between items; the block does not enforce this
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TIMEOUT: n_timeout = i_cfg_data;
                CFG_OFFLINE: n_offst = i_cfg_data[3:0];
                default: ;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                // take no item while reset is held
                o_s_tready = i_rst_n;
                if (i_s_tvalid) begin
                    case (i_s_tuser)
                        ACT_MSG: begin
                            n_id = i_s_tdata[30:0];
                            n_st = i_s_tdata[34:31];
                            n_idx = '0;
                            n_state = ST_MSG_RD;
                        end
                        ACT_TICK: n_clock = r_clock + 32'd1;
                        ACT_SWEEP: begin
                            n_idx = '0;
                            n_state = ST_SW_RD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MSG_RD: begin
                if (r_idx < r_count) begin
                    n_state = ST_MSG_CMP;
                end else if (r_count < DEPTH_C) begin
                    // unknown id: append at the end
                    mem_we = 1'b1;
                    mem_waddr = r_count[IW-1:0];
                    n_pos = r_count;
                    n_count = r_count + ONE_C;
                    n_ev = EV_ADDED;
                    n_state = ST_MSG_EMIT;
                end else begin
                    n_pos = '0;
                    n_ev = EV_DROPPED;
                    n_state = ST_MSG_EMIT;
                end
            end
            ST_MSG_CMP: begin
                if (mem_rdata.id == r_id) begin
                    // known id: refresh its time
                    mem_we = 1'b1;
                    n_pos = r_idx;
                    n_ev = EV_UPDATED;
                    n_state = ST_MSG_EMIT;
                end else begin
                    n_idx = r_idx + ONE_C;
                    n_state = ST_MSG_RD;
                end
            end
            ST_MSG_EMIT: begin
                if (out_free) begin
                    w_emit = 1'b1;
                    if (r_ev == EV_DROPPED) begin
                        n_state = ST_IDLE;
                    end else if (r_st == r_offst) begin
                        w_last = 1'b0;
                        n_j = r_pos;
                        n_ret = ST_OFF_EMIT;
                        n_state = ST_SHIFT_RD;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_SHIFT_RD: begin
                // move the entries above the gap down one slot
                if (w_j_next < r_count) begin
                    mem_raddr = w_j_next[IW-1:0];
                    n_state = ST_SHIFT_WR;
                end else begin
                    n_count = r_count - ONE_C;
                    n_state = r_ret;
                end
            end
            ST_SHIFT_WR: begin
                mem_we = 1'b1;
                mem_waddr = r_j[IW-1:0];
                mem_wdata = mem_rdata;
                n_j = w_j_next;
                n_state = ST_SHIFT_RD;
            end
            ST_OFF_EMIT: begin
                if (out_free) begin
                    w_emit = 1'b1;
                    w_ev = EV_OFFLINE;
                    n_state = ST_IDLE;
                end
            end
            ST_SW_RD: begin
                if (r_idx < r_count) begin
                    n_state = ST_SW_CMP;
                end else begin
                    n_state = ST_SW_DONE;
                end
            end
            ST_SW_CMP: begin
                if (w_age > {16'd0, r_timeout}) begin
                    n_gone = mem_rdata.id;
                    n_pos = r_idx;
                    n_j = r_idx;
                    n_ret = ST_SW_EMIT;
                    n_state = ST_SHIFT_RD;
                end else begin
                    n_idx = r_idx + ONE_C;
                    n_state = ST_SW_RD;
                end
            end
            ST_SW_EMIT: begin
                // hold the index: the next entry has moved into this slot
                if (out_free) begin
                    w_emit = 1'b1;
                    w_ev = EV_TIMEOUT;
                    w_oid = r_gone;
                    w_ost = 4'd0;
                    w_last = 1'b0;
                    n_state = ST_SW_RD;
                end
            end
            ST_SW_DONE: begin
                if (out_free) begin
                    w_emit = 1'b1;
                    w_ev = EV_DONE;
                    w_slot = '0;
                    w_oid = '0;
                    w_ost = 4'd0;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // output register: load on emit, drop once taken
    assign w_slot32 = 32'(w_slot);
    assign w_left32 = 32'(r_count);

    always_comb begin
        n_m_valid = r_m_valid && !i_m_tready;
        n_m_data = r_m_data;
        n_m_user = r_m_user;
        n_m_last = r_m_last;
        if (w_emit) begin
            n_m_valid = 1'b1;
            n_m_data = {4'd0, w_left32[4:0], w_ost, w_oid, w_slot32[3:0]};
            n_m_user = w_ev;
            n_m_last = w_last;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata = r_m_data;
    assign o_m_tuser = r_m_user;
    assign o_m_tlast = r_m_last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count beyond table depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_count == $past(r_count) || r_count == $past(r_count) + ONE_C
                  || r_count + ONE_C == $past(r_count)))
        else $error("entry count moved by more than one");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == EV_DONE || o_m_tuser == EV_OFFLINE)) |-> o_m_tlast)
        else $error("closing result without tlast");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit) |-> (!r_m_valid || i_m_tready))
        else $error("result emitted over a waiting one");
`endif

endmodule
